/* rtl/core/atr_pkg.sv */
// shared types, widths and constants for the accelerometer tilt block
// holds the atan(2^-i) angle table used by the cordic stages
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package atr_pkg;

  // default and upper bound of the cordic iteration count
  localparam int CordicStagesDef = 16;
  localparam int AngTableLen     = 24;

  // datapath widths: vector words and q16 degree accumulator
  localparam int WorkW = 42;
  localparam int AngW  = 27;

  // gain of the infinite cordic in q30, work scale shift
  localparam logic [30:0] GainQ30   = 31'd1768195363;
  localparam int          WorkShift = 20;

  // half turn in q16 degrees, output limits in degrees*128
  localparam logic signed [AngW-1:0] HalfTurnQ16 = 27'sd11796480;
  localparam logic signed [18:0]     RollLimit   = 19'sd23040;
  localparam logic signed [18:0]     PitchLimit  = 19'sd11520;

  // register index of the full scale setting
  localparam logic RegFullScale = 1'b0;

  // atan(2^-i) in degrees, q16
  function automatic logic signed [AngW-1:0] atan_q16(input int i);
    logic signed [AngW-1:0] v;
    case (i)
      0:       v = 27'sd2949120;
      1:       v = 27'sd1740967;
      2:       v = 27'sd919879;
      3:       v = 27'sd466945;
      4:       v = 27'sd234379;
      5:       v = 27'sd117305;
      6:       v = 27'sd58666;
      7:       v = 27'sd29335;
      8:       v = 27'sd14668;
      9:       v = 27'sd7334;
      10:      v = 27'sd3667;
      11:      v = 27'sd1833;
      12:      v = 27'sd917;
      13:      v = 27'sd458;
      14:      v = 27'sd229;
      15:      v = 27'sd115;
      16:      v = 27'sd57;
      17:      v = 27'sd29;
      18:      v = 27'sd14;
      19:      v = 27'sd7;
      20:      v = 27'sd4;
      21:      v = 27'sd2;
      22:      v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

  // sideband carried alongside the roll iterations
  typedef struct packed {
    logic signed [15:0] x_raw;
    logic signed [15:0] x_g;
    logic signed [15:0] y_g;
    logic signed [15:0] z_g;
    logic               nz;
  } roll_sb_t;

  // sideband carried alongside the pitch iterations
  typedef struct packed {
    logic signed [15:0]     x_g;
    logic signed [15:0]     y_g;
    logic signed [15:0]     z_g;
    logic signed [AngW-1:0] roll;
    logic                   nz;
  } pitch_sb_t;

endpackage
`default_nettype wire

/* rtl/core/accel_tilt_roll_pitch.sv */
// top level of the accelerometer tilt block: scaling, roll and pitch pipeline
// depends on atr_pkg and atr_cordic_stage
`timescale 1ns / 1ps
`default_nettype none
// Takes one raw three-axis sample per word and returns the axes in g (Q5.11,
// arithmetic shift by 3 - full scale) plus roll = atan2(y,z) and
// pitch = -atan2(x, |(y,z)|) in degrees*128. One word is accepted every cycle;
// unless the pipeline holds. A word passes an input stage, N registered cordic
// iterations for roll with N = min(CORDIC_STAGES, 24), a gain multiply stage,
// N iterations for pitch and a rounding stage. The whole pipeline holds
// while the output word is not taken. Full scale lives at APB address 0.
module accel_tilt_roll_pitch #(
  parameter int CORDIC_STAGES = atr_pkg::CordicStagesDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // apb configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,  // accel_x_raw, accel_y_raw, accel_z_raw
  // result words
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [79:0] m_axis_tdata   // accel_x_g, accel_y_g, accel_z_g, roll_deg,
                                     // pitch_deg, 1 zero bit
);
  import atr_pkg::*;

  localparam int N = (CORDIC_STAGES < AngTableLen) ? CORDIC_STAGES : AngTableLen;
  localparam int L = 2 * N + 3;  // pipeline length

  // full scale register
  logic [1:0] fs_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= 2'd0;
    end else if (psel && penable && pwrite && (paddr[2] == RegFullScale)) begin
      fs_q <= pwdata[1:0];
    end
  end
  assign prdata = (paddr[2] == RegFullScale) ? {30'd0, fs_q} : 32'd0;

  // global advance and valid bits
  logic         en;
  logic [L-1:0] v_q;
  assign en            = !v_q[L-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[L-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[L-2:0], s_axis_tvalid};
    end
  end

  // input stage: scaling, half turn fold for negative z
  logic signed [15:0]      ix, iy, iz;
  logic [1:0]              sh;
  logic signed [WorkW-1:0] zw, yw;
  roll_sb_t                rsb_d;
  logic signed [WorkW-1:0] rx0_d, ry0_d;
  logic signed [AngW-1:0]  ra0_d;

  always_comb begin
    ix = s_axis_tdata[15:0];
    iy = s_axis_tdata[31:16];
    iz = s_axis_tdata[47:32];
    sh = 2'd3 - fs_q;
    zw = WorkW'(iz) <<< WorkShift;
    yw = WorkW'(iy) <<< WorkShift;
    rsb_d.x_raw = ix;
    rsb_d.x_g   = ix >>> sh;
    rsb_d.y_g   = iy >>> sh;
    rsb_d.z_g   = iz >>> sh;
    rsb_d.nz    = (iy != 16'sd0) || (iz != 16'sd0);
    if (iz[15]) begin
      rx0_d = -zw;
      ry0_d = -yw;
      ra0_d = iy[15] ? -HalfTurnQ16 : HalfTurnQ16;
    end else begin
      rx0_d = zw;
      ry0_d = yw;
      ra0_d = '0;
    end
  end

  // roll chain
  logic signed [WorkW-1:0] rx [0:N];
  logic signed [WorkW-1:0] ry [0:N];
  logic signed [AngW-1:0]  ra [0:N];
  roll_sb_t                rsb [0:N];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx[0]  <= rx0_d;
      ry[0]  <= ry0_d;
      ra[0]  <= ra0_d;
      rsb[0] <= rsb_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_roll
    atr_cordic_stage #(.SHIFT(i)) u_stage (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (rx[i]),
      .y_i   (ry[i]),
      .acc_i (ra[i]),
      .x_o   (rx[i+1]),
      .acc_o (ra[i+1]),
      .y_o   (ry[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        rsb[i+1] <= rsb[i];
      end
    end
  end

  // gain stage: x times infinite cordic gain, zero checks
  logic signed [46:0]      prod;
  logic signed [WorkW-1:0] mag, px0_d, py0_d;
  pitch_sb_t               psb_d;

  always_comb begin
    mag   = rsb[N].nz ? rx[N] : '0;
    prod  = $signed({{31{rsb[N].x_raw[15]}}, rsb[N].x_raw}) * $signed({16'd0, GainQ30});
    px0_d = mag;
    py0_d = WorkW'($signed(prod[46:10]));
    psb_d.x_g  = rsb[N].x_g;
    psb_d.y_g  = rsb[N].y_g;
    psb_d.z_g  = rsb[N].z_g;
    psb_d.roll = rsb[N].nz ? ra[N] : '0;
    psb_d.nz   = (rsb[N].x_raw != 16'sd0) || (mag != '0);
  end

  // pitch chain
  logic signed [WorkW-1:0] px [0:N];
  logic signed [WorkW-1:0] py [0:N];
  logic signed [AngW-1:0]  pa [0:N];
  pitch_sb_t               psb [0:N];

  always_ff @(posedge clk_i) begin
    if (en) begin
      px[0]  <= px0_d;
      py[0]  <= py0_d;
      pa[0]  <= '0;
      psb[0] <= psb_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_pitch
    atr_cordic_stage #(.SHIFT(i)) u_stage (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (px[i]),
      .y_i   (py[i]),
      .acc_i (pa[i]),
      .x_o   (px[i+1]),
      .acc_o (pa[i+1]),
      .y_o   (py[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        psb[i+1] <= psb[i];
      end
    end
  end

  // output stage: round to nearest and saturate
  logic signed [AngW:0] rsum, psum;
  logic signed [18:0]   rq, pq;
  logic signed [15:0]   roll_d;
  logic signed [14:0]   pitch_d;
  logic [79:0]          out_q;

  always_comb begin
    rsum = {psb[N].roll[AngW-1], psb[N].roll} + (AngW+1)'(256);
    psum = psb[N].nz ? (-{pa[N][AngW-1], pa[N]}) + (AngW+1)'(256) : (AngW+1)'(256);
    rq   = 19'(rsum >>> 9);
    pq   = 19'(psum >>> 9);
    if (rq > RollLimit) begin
      roll_d = 16'(RollLimit);
    end else if (rq < -RollLimit) begin
      roll_d = 16'(-RollLimit);
    end else begin
      roll_d = rq[15:0];
    end
    if (pq > PitchLimit) begin
      pitch_d = 15'(PitchLimit);
    end else if (pq < -PitchLimit) begin
      pitch_d = 15'(-PitchLimit);
    end else begin
      pitch_d = pq[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {1'b0, pitch_d, roll_d, psb[N].z_g, psb[N].y_g, psb[N].x_g};
    end
  end

  assign m_axis_tdata = out_q;

endmodule
`default_nettype wire

/* rtl/core/atr_cordic_stage.sv */
// one registered vectoring cordic iteration with a fixed shift
// depends on atr_pkg for widths and the angle table
`timescale 1ns / 1ps
`default_nettype none
module atr_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  wire                                  clk_i,
  input  wire                                  en_i,
  input  wire logic signed [atr_pkg::WorkW-1:0] x_i,
  input  wire logic signed [atr_pkg::WorkW-1:0] y_i,
  input  wire logic signed [atr_pkg::AngW-1:0]  acc_i,
  output logic signed [atr_pkg::WorkW-1:0]      x_o,
  output logic signed [atr_pkg::AngW-1:0]       acc_o,
  output logic signed [atr_pkg::WorkW-1:0]      y_o
);
  import atr_pkg::*;

  localparam logic signed [AngW-1:0] Ang = atan_q16(SHIFT);

  logic signed [WorkW-1:0] dx, dy, x_d, y_d;
  logic signed [AngW-1:0]  acc_d;

  // rotate toward the x axis
  always_comb begin
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    if (!y_i[WorkW-1]) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      acc_d = acc_i + Ang;
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      acc_d = acc_i - Ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o   <= x_d;
      y_o   <= y_d;
      acc_o <= acc_d;
    end
  end

endmodule
`default_nettype wire

/* test/tb_top.sv */
// self-checking testbench for accel_tilt_roll_pitch: directed table then random samples
// predicts scaled axes, roll and pitch with its own cordic and checks every result word
// depends on atr_pkg and the accel_tilt_roll_pitch rtl
`timescale 1ns / 1ps
module tb_top;
  import atr_pkg::*;

  localparam int NumRand  = 400;
  localparam int CycLimit = 400000;
  localparam logic [2:0] AddrFullScale = 3'd0;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] xg;
    logic signed [15:0] yg;
    logic signed [15:0] zg;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
  } tilt_t;

  // directed row: sample plus optional typed-in angles
  typedef struct {
    sample_t    s;
    bit         known;
    logic [15:0] roll;
    logic [14:0] pitch;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // accel_x_raw, accel_y_raw, accel_z_raw
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;       // accel_x_g, accel_y_g, accel_z_g, roll_deg, pitch_deg, pad

  accel_tilt_roll_pitch u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [1:0] full_scale;
  tilt_t      pending_tilt[$];
  bit         angle_known[$];
  int         errors = 0;
  int         cycles = 0;
  int         send_idle = 0;
  int         recv_stall = 0;

  function automatic logic signed [63:0] shr(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  // vectoring iterations on (xv, yv), angle in q16 degrees
  function automatic logic signed [63:0] vec_angle(logic signed [63:0] xv,
      logic signed [63:0] yv, output logic signed [63:0] mag);
    logic signed [63:0] acc, dx, dy;
    acc = 0;
    for (int i = 0; i < CordicStagesDef && i < AngTableLen; i++) begin
      dx = shr(yv, i);
      dy = shr(xv, i);
      if (yv >= 0) begin
        xv = xv + dx; yv = yv - dy; acc = acc + 64'(atan_q16(i));
      end else begin
        xv = xv - dx; yv = yv + dy; acc = acc - 64'(atan_q16(i));
      end
    end
    mag = xv;
    return acc;
  endfunction

  function automatic logic signed [63:0] round_sat(logic signed [63:0] a, int lim);
    logic signed [63:0] q;
    q = shr(a + 256, 9);
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic tilt_t predict_tilt(sample_t s, logic [1:0] fs);
    tilt_t r;
    int sh;
    logic signed [63:0] x, y, z, xv, yv, base, roll, pitch, mag, unused, xk;
    sh = 3 - fs;
    x = s.x; y = s.y; z = s.z;
    r.xg = 16'(shr(x, sh));
    r.yg = 16'(shr(y, sh));
    r.zg = 16'(shr(z, sh));
    roll = 0; pitch = 0; mag = 0;
    if (y != 0 || z != 0) begin
      xv = z <<< WorkShift;
      yv = y <<< WorkShift;
      base = 0;
      if (z < 0) begin
        xv = -xv; yv = -yv;
        base = (y >= 0) ? 64'(HalfTurnQ16) : -64'(HalfTurnQ16);
      end
      roll = base + vec_angle(xv, yv, mag);
    end
    if (x != 0 || mag != 0) begin
      xk = shr(x * $signed({33'd0, GainQ30}), 10);
      pitch = -vec_angle(mag, xk, unused);
    end
    r.roll  = 16'(round_sat(roll, 23040));
    r.pitch = 15'(round_sat(pitch, 11520));
    return r;
  endfunction

  task automatic write_full_scale(logic [1:0] v, logic [31:0] upper);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = AddrFullScale;
    pwdata = {upper[31:2], v};
    @(negedge clk_i) penable = 1'b1;
    @(posedge clk_i) full_scale = v;
    @(negedge clk_i) begin psel = 1'b0; penable = 1'b0; pwrite = 1'b0; end
  endtask

  task automatic send_sample(sample_t s, bit known, logic [15:0] roll, logic [14:0] pitch);
    tilt_t t;
    while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge clk_i);
    t = predict_tilt(s, full_scale);
    if (known) begin
      t.roll = roll; t.pitch = pitch;
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {s.z, s.y, s.x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_tilt.push_back(t);
    angle_known.push_back(known);
    @(negedge clk_i) s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pending_tilt.size() != 0) @(negedge clk_i);
    repeat (2 * CordicStagesDef + 10) @(negedge clk_i);
  endtask

  // random receiver stall
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall);

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    tilt_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.xg    = m_axis_tdata[15:0];
      got.yg    = m_axis_tdata[31:16];
      got.zg    = m_axis_tdata[47:32];
      got.roll  = m_axis_tdata[63:48];
      got.pitch = m_axis_tdata[78:64];
      if (pending_tilt.size() == 0) begin
        $display("%0t unexpected result word %h", $time, got);
        errors++;
      end else begin
        want = pending_tilt.pop_front();
        void'(angle_known.pop_front());
        if (got !== want) begin
          $display("%0t mismatch expected x %0d y %0d z %0d roll %0d pitch %0d", $time,
                   want.xg, want.yg, want.zg, want.roll, want.pitch);
          $display("%0t              actual x %0d y %0d z %0d roll %0d pitch %0d", $time,
                   got.xg, got.yg, got.zg, got.roll, got.pitch);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycLimit) begin
      $display("FAIL accel_tilt_roll_pitch");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'($signed($urandom_range(16)) - 8);
      3:       return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    row_t rows[$];
    sample_t s;
    rows = '{
      '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, 16'sd0, 15'sd0},
      '{'{16'sd100, 16'sd0, 16'sd0}, 1'b1, 16'sd0, -15'sd11520},
      '{'{-16'sd100, 16'sd0, 16'sd0}, 1'b1, 16'sd0, 15'sd11520},
      '{'{16'sd0, 16'sd0, 16'sd16384}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sd0, 16'sd0, -16'sd16384}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sd0, 16'sd5, -16'sd16384}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sd0, -16'sd5, -16'sd16384}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sd0, 16'sd16384, 16'sd0}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sd0, -16'sd16384, 16'sd0}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sh8000, 16'sh7fff, 16'sh8000}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sh7fff, 16'sh8000, 16'sh7fff}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sd1, 16'sd1, 16'sd1}, 1'b0, 16'sd0, 15'sd0},
      '{'{-16'sd1, -16'sd1, -16'sd1}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sd0, 16'sd1, -16'sd1}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sd0, -16'sd1, -16'sd1}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'sh5555, 16'shaaaa, 16'sh5555}, 1'b0, 16'sd0, 15'sd0},
      '{'{16'shaaaa, 16'sh5555, 16'shaaaa}, 1'b0, 16'sd0, 15'sd0}
    };
    full_scale = 2'd0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(negedge clk_i);

    // all directed rows at the reset setting, then the first five at the widest range
    foreach (rows[i]) send_sample(rows[i].s, rows[i].known, rows[i].roll, rows[i].pitch);
    drain();
    write_full_scale(2'd3, 32'hffff_fffc);
    foreach (rows[i]) if (i < 5) send_sample(rows[i].s, rows[i].known, rows[i].roll,
                                             rows[i].pitch);
    drain();

    // random phases across idling styles and ranges
    for (int ph = 0; ph < 8; ph++) begin
      write_full_scale(2'(ph), $urandom);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 72; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 72; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      for (int n = 0; n < NumRand / 8; n++) begin
        s.x = rand_axis(); s.y = rand_axis(); s.z = rand_axis();
        send_sample(s, 1'b0, '0, '0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS accel_tilt_roll_pitch");
    end else begin
      $display("FAIL accel_tilt_roll_pitch");
    end
    $finish;
  end

endmodule
